>>> src/bgs_pkg.sv
// Barrier gate sequencer: shared widths, reset values, codes and the divider interface types.
// No dependencies; imported by bgs_divider and barrier_gate_sequencer.
`timescale 1ns / 1ps

package bgs_pkg;

  localparam int POS_BITS   = 16;
  localparam int CNT_W      = 16;
  localparam int PULSE_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int T_W        = CNT_W + 3;
  localparam int DIV_NUM_W  = CNT_W + POS_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam int PROD_W     = PULSE_W + POS_BITS;

  localparam logic [POS_BITS-1:0] POS_FULL = '1;
  localparam logic [CNT_W-1:0]    CNT_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_US    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_US   = 3'd6;

  localparam int RST_TRAVEL_INT = 500;
  localparam int FULL_INT       = (1 << POS_BITS) - 1;

  localparam logic [CNT_W-1:0]    RST_ON_DELAY   = 16'd25;
  localparam logic [CNT_W-1:0]    RST_YELLOW     = 16'd25;
  localparam logic [CNT_W-1:0]    RST_GATE_DELAY = 16'd50;
  localparam logic [CNT_W-1:0]    RST_TRAVEL     = CNT_W'(RST_TRAVEL_INT);
  localparam logic [POS_BITS-1:0] RST_SLEW       = 16'd131;
  localparam logic [PULSE_W-1:0]  RST_VERT_US    = 12'd2050;
  localparam logic [PULSE_W-1:0]  RST_HORIZ_US   = 12'd1050;
  localparam logic [POS_BITS-1:0] RST_STEP_Q     = POS_BITS'(FULL_INT / RST_TRAVEL_INT);
  localparam logic [CNT_W-1:0]    RST_STEP_R     = CNT_W'(FULL_INT % RST_TRAVEL_INT);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_YELLOW     = 3'd1,
    PH_RED_WAIT   = 3'd2,
    PH_LOWERING   = 3'd3,
    PH_LOWERED    = 3'd4,
    PH_SWITCH_OFF = 3'd5
  } phase_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [CNT_W-1:0]     den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [CNT_W-1:0]     rem;
  } div_rsp_t;

endpackage

>>> src/barrier_gate_sequencer.sv
// Barrier gate sequencer top level: tick pipeline, configuration registers, ramp set-up.
// Depends on bgs_pkg and bgs_divider.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one transaction per control tick, carrying the switch level.
//   out_* : one transaction per tick: lamps, servo pulse width, barrier position, phase.
//   cfg_* : register writes (index 0..6, higher indexes ignored), only while idle.
// Pipeline: a tick is held in an input register, then its result is registered and
//   out_valid rises. Throughput is one tick per cycle unless out_stall or a set-up holds it.
// Ramp: the lowering target is tracked incrementally as quotient and remainder of
//   k * full_scale / travel_ticks. A write to any of registers 0..3 starts two
//   divisions on the shared divider, step then accumulator; cfg_ready and
//   in_stall hold off further transactions until they finish.
// Reset (synchronous, rst_n low): registers take their default values, count and
//   position clear, both channels empty; no set-up pass is needed.
// Stall: if out_stall holds a result, one further tick is taken into the input
//   register, after which in_stall rises until the result is taken.
//

module barrier_gate_sequencer
  import bgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_switch_on,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_yellow_lamp,
  output logic                  out_red_lamp,
  output logic [PULSE_W-1:0]    out_pulse_width_us,
  output logic [POS_BITS-1:0]   out_barrier_position,
  output logic [2:0]            out_phase,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_STEP_GO  = 5'b00010,
    ST_STEP_RUN = 5'b00100,
    ST_ACC_GO   = 5'b01000,
    ST_ACC_RUN  = 5'b10000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    on_delay_r, yellow_r, gate_delay_r, travel_r;
  logic [POS_BITS-1:0] slew_r;
  logic [PULSE_W-1:0]  vert_us_r, horiz_us_r;

  logic [POS_BITS-1:0] step_q_r;
  logic [CNT_W-1:0]    step_r_r;
  logic [POS_BITS-1:0] acc_q_r, acc_q_nxt;
  logic [CNT_W-1:0]    acc_r_r, acc_r_nxt;
  logic [DIV_NUM_W-1:0] num_r;

  logic [CNT_W-1:0]    elapsed_r, elapsed_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;

  logic a_valid_r, a_switch_r;
  logic out_valid_r;
  logic yellow_nxt, red_nxt;
  phase_t phase_nxt;
  logic [PULSE_W-1:0] pulse_nxt;
  logic yellow_lamp_r, red_r;
  logic [PULSE_W-1:0] pulse_r;
  logic [POS_BITS-1:0] pos_out_r;
  phase_t phase_r;

  logic busy, cfg_wr, in_acc, adv;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Thresholds
  logic [T_W-1:0] t1, t2, t3, t4, e_ext;
  logic           inc;

  assign t1 = T_W'(on_delay_r);
  assign t2 = t1 + T_W'(yellow_r);
  assign t3 = t2 + T_W'(gate_delay_r);
  assign t4 = t3 + T_W'(travel_r);

  // Handshakes
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign adv       = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = busy || (a_valid_r && !adv);
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_delay_r   <= RST_ON_DELAY;
      yellow_r     <= RST_YELLOW;
      gate_delay_r <= RST_GATE_DELAY;
      travel_r     <= RST_TRAVEL;
      slew_r       <= RST_SLEW;
      vert_us_r    <= RST_VERT_US;
      horiz_us_r   <= RST_HORIZ_US;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ON_DELAY:   on_delay_r   <= cfg_data[CNT_W-1:0];
        CFG_YELLOW:     yellow_r     <= cfg_data[CNT_W-1:0];
        CFG_GATE_DELAY: gate_delay_r <= cfg_data[CNT_W-1:0];
        CFG_TRAVEL:     travel_r     <= cfg_data[CNT_W-1:0];
        CFG_SLEW:       slew_r       <= cfg_data[POS_BITS-1:0];
        CFG_VERT_US:    vert_us_r    <= cfg_data[PULSE_W-1:0];
        CFG_HORIZ_US:   horiz_us_r   <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Ramp set-up sequencer
  logic [CNT_W-1:0]     k_now;
  logic [DIV_NUM_W-1:0] k_full;

  always_comb begin
    k_now  = (T_W'(elapsed_r) >= t3) ? elapsed_r - t3[CNT_W-1:0] : '0;
    k_full = {k_now, POS_BITS'(0)} - DIV_NUM_W'(k_now);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_wr && cfg_index <= CFG_TRAVEL) state_nxt = ST_STEP_GO;
      end
      ST_STEP_GO:  state_nxt = ST_STEP_RUN;
      ST_STEP_RUN: begin
        if (div_rsp.done) state_nxt = ST_ACC_GO;
      end
      ST_ACC_GO:   state_nxt = ST_ACC_RUN;
      ST_ACC_RUN: begin
        if (div_rsp.done) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    div_req.start = (state_r == ST_STEP_GO) || (state_r == ST_ACC_GO);
    div_req.num   = (state_r == ST_STEP_GO) ? DIV_NUM_W'(POS_FULL) : num_r;
    div_req.den   = travel_r;
  end

  bgs_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_STEP_RUN && div_rsp.done) num_r <= k_full;
  end

  // Tick datapath
  logic                on;
  logic [POS_BITS-1:0] target;
  logic [POS_BITS:0]   q_sum, slew_sum;
  logic [CNT_W:0]      r_sum;
  logic                wrap;
  logic [PULSE_W-1:0]  mag;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     prod_dn;
  logic [PULSE_W:0]    down;

  always_comb begin
    on          = a_switch_r;
    inc         = on && (elapsed_r != CNT_MAX);
    elapsed_nxt = !on ? '0 : (inc ? elapsed_r + 1'b1 : elapsed_r);
    e_ext       = T_W'(elapsed_nxt);

    r_sum = {1'b0, acc_r_r} + {1'b0, step_r_r};
    wrap  = r_sum >= {1'b0, travel_r};
    q_sum = {1'b0, acc_q_r} + {1'b0, step_q_r} + (POS_BITS + 1)'(wrap);

    acc_q_nxt = acc_q_r;
    acc_r_nxt = acc_r_r;
    if (!on) begin
      acc_q_nxt = '0;
      acc_r_nxt = '0;
    end else if (inc) begin
      if (e_ext <= t3) begin
        acc_q_nxt = '0;
        acc_r_nxt = '0;
      end else if (e_ext < t4) begin
        acc_q_nxt = q_sum[POS_BITS-1:0];
        acc_r_nxt = wrap ? CNT_W'(r_sum - {1'b0, travel_r}) : r_sum[CNT_W-1:0];
      end
    end

    yellow_nxt = 1'b0;
    red_nxt    = 1'b0;
    target     = '0;
    if (!on) begin
      phase_nxt = PH_SWITCH_OFF;
      red_nxt   = pos_r != '0;
    end else if (e_ext < t1) begin
      phase_nxt = PH_IDLE;
    end else if (e_ext < t2) begin
      phase_nxt  = PH_YELLOW;
      yellow_nxt = 1'b1;
    end else if (e_ext < t3) begin
      phase_nxt = PH_RED_WAIT;
      red_nxt   = 1'b1;
    end else if (e_ext < t4) begin
      phase_nxt = PH_LOWERING;
      red_nxt   = 1'b1;
      target    = acc_q_nxt;
    end else begin
      phase_nxt = PH_LOWERED;
      red_nxt   = 1'b1;
      target    = POS_FULL;
    end

    slew_sum = {1'b0, pos_r} + {1'b0, slew_r};
    if (pos_r < target) begin
      pos_nxt = (slew_sum > {1'b0, target}) ? target : slew_sum[POS_BITS-1:0];
    end else if (pos_r > target) begin
      pos_nxt = (pos_r - target < slew_r) ? target : pos_r - slew_r;
    end else begin
      pos_nxt = pos_r;
    end

    mag     = (horiz_us_r >= vert_us_r) ? horiz_us_r - vert_us_r : vert_us_r - horiz_us_r;
    prod    = PROD_W'(mag) * PROD_W'(pos_nxt);
    prod_dn = {1'b0, prod} + (PROD_W + 1)'(POS_FULL);
    down    = prod_dn[PROD_W:POS_BITS];
    if (horiz_us_r >= vert_us_r) begin
      pulse_nxt = vert_us_r + prod[PROD_W-1:POS_BITS];
    end else if (down > {1'b0, vert_us_r}) begin
      pulse_nxt = '0;
    end else begin
      pulse_nxt = vert_us_r - down[PULSE_W-1:0];
    end
  end

  // State and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
      pos_r       <= '0;
      acc_q_r     <= '0;
      acc_r_r     <= '0;
      step_q_r    <= RST_STEP_Q;
      step_r_r    <= RST_STEP_R;
    end else begin
      if (in_acc)   a_valid_r <= 1'b1;
      else if (adv) a_valid_r <= 1'b0;

      if (adv)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (adv) begin
        elapsed_r <= elapsed_nxt;
        pos_r     <= pos_nxt;
        acc_q_r   <= acc_q_nxt;
        acc_r_r   <= acc_r_nxt;
      end else if (state_r == ST_ACC_RUN && div_rsp.done) begin
        acc_q_r <= div_rsp.quo[POS_BITS-1:0];
        acc_r_r <= div_rsp.rem;
      end

      if (state_r == ST_STEP_RUN && div_rsp.done) begin
        step_q_r <= div_rsp.quo[POS_BITS-1:0];
        step_r_r <= div_rsp.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) a_switch_r <= in_switch_on;
    if (adv) begin
      yellow_lamp_r <= yellow_nxt;
      red_r         <= red_nxt;
      pulse_r       <= pulse_nxt;
      pos_out_r     <= pos_nxt;
      phase_r       <= phase_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_yellow_lamp      = yellow_lamp_r;
  assign out_red_lamp         = red_r;
  assign out_pulse_width_us   = pulse_r;
  assign out_barrier_position = pos_out_r;
  assign out_phase            = phase_r;

endmodule

>>> src/bgs_divider.sv
// Restoring divider, one quotient bit per cycle, for the ramp step and ramp accumulator.
// Depends on bgs_pkg.
`timescale 1ns / 1ps

module bgs_divider
  import bgs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     den_r;

  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W:0]       diff;

  always_comb begin
    trial = {rem_r, quo_r[DIV_NUM_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
    end else if (run_r && cnt_r == CNT_LAST) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule
